// File: rtl/core/dstp_pkg.sv
// Shared types, constants and helpers for the display strip test pattern.
`default_nettype none
package dstp_pkg;

	typedef enum logic [1:0] {
		MODE_BLACK   = 2'd0,
		MODE_WHITE   = 2'd1,
		MODE_CHECKER = 2'd2,
		MODE_GRID    = 2'd3
	} mode_t;

	localparam logic REG_PATTERN_MODE = 1'b0;
	localparam logic REG_STRIP_HEIGHT = 1'b1;

	localparam int CFG_W  = 10;
	localparam int ROWS_W = 8;
	localparam int GAP_W  = 4;
	localparam int PIX_W  = 16;
	localparam int BAR_W  = 9;

	localparam logic [PIX_W-1:0]  PIX_WHITE  = 16'hFFFF;
	localparam logic [PIX_W-1:0]  PIX_BLACK  = 16'h0000;
	localparam logic [GAP_W-1:0]  GAP_LAST   = 4'd11;
	localparam logic [BAR_W-1:0]  GAP_ORIGIN = 9'd8;
	localparam logic [BAR_W-1:0]  GAP_WIDTH  = 9'd24;
	localparam logic [ROWS_W-2:0] BAR_HALF   = 7'd4;

	localparam mode_t            MODE_RESET   = MODE_GRID;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd50;

	function automatic logic [ROWS_W-1:0] clamp_rows(input logic [CFG_W-1:0] h,
		input logic [ROWS_W-1:0] max_rows);
		logic [CFG_W-1:0] c;
		c = h;
		if (c < 10'd2) c = 10'd2;
		if (c > {2'b00, max_rows}) c = {2'b00, max_rows};
		return {c[ROWS_W-1:1], 1'b0};
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/dstp_raster.sv
// Raster position, strip counters and frame wrap.
`default_nettype none
module dstp_raster import dstp_pkg::*; #(
	parameter int FRAME_WIDTH  = 410,
	parameter int FRAME_HEIGHT = 502,
	parameter logic [ROWS_W-1:0] RESET_ROWS = 8'd50,
	localparam int CW = $clog2(FRAME_WIDTH),
	localparam int LW = $clog2(FRAME_HEIGHT)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              restart,
	input  wire logic [ROWS_W-1:0] strip_rows,
	output logic      [CW-1:0]     col,
	output logic      [LW-1:0]     line,
	output logic      [ROWS_W-1:0] row,
	output logic      [ROWS_W-1:0] strip,
	output logic      [GAP_W-1:0]  gap,
	output logic      [ROWS_W-1:0] rows,
	output logic                   last
);

	logic [CW-1:0]     col_q;
	logic [LW-1:0]     line_q;
	logic [ROWS_W-1:0] row_q;
	logic [ROWS_W-1:0] strip_q;
	logic [GAP_W-1:0]  gap_q;
	logic [ROWS_W-1:0] rows_q;
	logic              line_end;
	logic [ROWS_W:0]   row_inc;

	always_comb begin
		if (restart) begin
			col   = '0;
			line  = '0;
			row   = '0;
			strip = '0;
			gap   = '0;
			rows  = strip_rows;
		end else begin
			col   = col_q;
			line  = line_q;
			row   = row_q;
			strip = strip_q;
			gap   = gap_q;
			rows  = rows_q;
		end
	end

	assign line_end = (col == CW'(FRAME_WIDTH - 1));
	assign last     = line_end && (line == LW'(FRAME_HEIGHT - 1));
	assign row_inc  = {1'b0, row} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			line_q  <= '0;
			row_q   <= '0;
			strip_q <= '0;
			gap_q   <= '0;
			rows_q  <= RESET_ROWS;
		end else if (advance) begin
			if (last) begin
				col_q   <= '0;
				line_q  <= '0;
				row_q   <= '0;
				strip_q <= '0;
				gap_q   <= '0;
				rows_q  <= strip_rows;
			end else if (line_end) begin
				col_q  <= '0;
				line_q <= line + 1'b1;
				rows_q <= rows;
				if (row_inc >= {1'b0, rows}) begin
					row_q   <= '0;
					strip_q <= strip + 1'b1;
					gap_q   <= (gap == GAP_LAST) ? '0 : gap + 1'b1;
				end else begin
					row_q   <= row_inc[ROWS_W-1:0];
					strip_q <= strip;
					gap_q   <= gap;
				end
			end else begin
				col_q   <= col + 1'b1;
				line_q  <= line;
				row_q   <= row;
				strip_q <= strip;
				gap_q   <= gap;
				rows_q  <= rows;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/dstp_pixel.sv
// Pixel color for the selected pattern mode at one raster position.
`default_nettype none
module dstp_pixel import dstp_pkg::*; #(
	parameter int FRAME_WIDTH  = 410,
	parameter int FRAME_HEIGHT = 502,
	localparam int CW = $clog2(FRAME_WIDTH),
	localparam int LW = $clog2(FRAME_HEIGHT),
	localparam int SW = (LW + 1 > ROWS_W) ? LW + 1 : ROWS_W
) (
	input  wire mode_t             mode,
	input  wire logic [CW-1:0]     col,
	input  wire logic [LW-1:0]     line,
	input  wire logic [ROWS_W-1:0] row,
	input  wire logic [GAP_W-1:0]  gap,
	input  wire logic [ROWS_W-1:0] rows,
	output logic      [PIX_W-1:0]  pixel
);

	logic [LW:0]       line_x;
	logic [SW-1:0]     left;
	logic [ROWS_W-1:0] height;
	logic [ROWS_W-2:0] mid;
	logic [ROWS_W-2:0] lo;
	logic [ROWS_W-1:0] hi;
	logic [BAR_W-1:0]  gap_lo;
	logic [BAR_W-1:0]  gap_hi;
	logic              in_bar;
	logic              in_gap;
	logic [PIX_W-1:0]  check_pix;
	logic [PIX_W-1:0]  grid;

	assign line_x    = {1'b0, line};
	assign check_pix = (col[4] ^ line_x[4]) ? PIX_WHITE : PIX_BLACK;

	assign left   = SW'(FRAME_HEIGHT) - (SW'(line) - SW'(row));
	assign height = (SW'(rows) > left) ? left[ROWS_W-1:0] : rows;
	assign mid    = height[ROWS_W-1:1];
	assign lo     = (mid >= BAR_HALF) ? mid - BAR_HALF : '0;
	assign hi     = {1'b0, mid} + {1'b0, BAR_HALF};
	assign in_bar = (row >= {1'b0, lo}) && (row < hi) && (row < height);

	assign gap_lo = GAP_ORIGIN + {gap, 5'b00000};
	assign gap_hi = gap_lo + GAP_WIDTH;
	assign in_gap = (col >= CW'(gap_lo)) && (col < CW'(gap_hi));

	assign grid = in_bar ? (in_gap ? PIX_BLACK : PIX_WHITE) : check_pix;

	always_comb begin
		unique case (mode)
			MODE_BLACK:   pixel = PIX_BLACK;
			MODE_WHITE:   pixel = PIX_WHITE;
			MODE_CHECKER: pixel = check_pix;
			MODE_GRID:    pixel = grid;
			default:      pixel = PIX_BLACK;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/display_strip_test_pattern.sv
// Top level: configuration registers, raster, pixel logic and result register.
// A result word is registered and valid the cycle after its request word is accepted.
// Throughput: one pixel per cycle while result_ready is not stalling, set by the single result register stage.
// A request is taken whenever the result register is empty or being drained.
// Reset: raster at (0,0), strip counters zero, mode grid, strip height 50.
`default_nettype none
module display_strip_test_pattern import dstp_pkg::*; #(
	parameter int FRAME_WIDTH  = 410,
	parameter int FRAME_HEIGHT = 502,
	parameter int MAX_STRIP    = 250
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire logic             restart,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output logic      [15:0]      pixel,
	output logic      [8:0]       column,
	output logic      [8:0]       line,
	output logic      [7:0]       strip_number,
	output logic                  frame_end
);

	localparam int CW = $clog2(FRAME_WIDTH);
	localparam int LW = $clog2(FRAME_HEIGHT);
	localparam logic [ROWS_W-1:0] MAX_ROWS   = ROWS_W'(MAX_STRIP);
	localparam logic [ROWS_W-1:0] RESET_ROWS = clamp_rows(HEIGHT_RESET, MAX_ROWS);

	mode_t             mode_q;
	logic [CFG_W-1:0]  height_q;
	logic              accept;
	logic [ROWS_W-1:0] strip_rows;
	logic [CW-1:0]     col;
	logic [LW-1:0]     ln;
	logic [ROWS_W-1:0] row;
	logic [ROWS_W-1:0] strip;
	logic [GAP_W-1:0]  gap;
	logic [ROWS_W-1:0] rows;
	logic              last;
	logic [PIX_W-1:0]  pix;

	logic              valid_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic [8:0]        column_s1;
	logic [8:0]        line_s1;
	logic [7:0]        strip_s1;
	logic              last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_MODE: mode_q   <= mode_t'(cfg_data[1:0]);
				REG_STRIP_HEIGHT: height_q <= cfg_data;
				default:          height_q <= height_q;
			endcase
		end
	end

	assign strip_rows = clamp_rows(height_q, MAX_ROWS);
	assign item_ready = !valid_s1 || result_ready;
	assign accept     = item_valid && item_ready;

	dstp_raster #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.RESET_ROWS   (RESET_ROWS)
	) u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.restart    (restart),
		.strip_rows (strip_rows),
		.col        (col),
		.line       (ln),
		.row        (row),
		.strip      (strip),
		.gap        (gap),
		.rows       (rows),
		.last       (last)
	);

	dstp_pixel #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_pixel (
		.mode  (mode_q),
		.col   (col),
		.line  (ln),
		.row   (row),
		.gap   (gap),
		.rows  (rows),
		.pixel (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1  <= pix;
			column_s1 <= 9'(col);
			line_s1   <= 9'(ln);
			strip_s1  <= (mode_q == MODE_GRID) ? strip : '0;
			last_s1   <= last;
		end
	end

	assign result_valid = valid_s1;
	assign pixel        = pixel_s1;
	assign column       = column_s1;
	assign line         = line_s1;
	assign strip_number = strip_s1;
	assign frame_end    = last_s1;

endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the display strip test pattern generator.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import dstp_pkg::*;

	localparam int FRAME_W   = 410;
	localparam int FRAME_H   = 502;
	localparam int MAX_STRIP = 250;
	localparam int GAP_PITCH = 32;

	typedef struct {
		logic [15:0] pixel;
		logic [8:0]  column;
		logic [8:0]  line;
		logic [7:0]  strip_number;
		logic        frame_end;
	} pix_word_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic             cfg_index    = 1'b0;
	logic [CFG_W-1:0] cfg_data     = '0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	logic             restart      = 1'b0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic [15:0]      pixel;
	logic [8:0]       column;
	logic [8:0]       line;
	logic [7:0]       strip_number;
	logic             frame_end;

	mode_t            cur_mode   = MODE_RESET;
	logic [CFG_W-1:0] cur_height = HEIGHT_RESET;
	logic [8:0]       ras_col;
	logic [8:0]       ras_line;
	logic [7:0]       ras_row;
	logic [7:0]       ras_strip;
	logic [3:0]       ras_gap;
	logic [7:0]       ras_rows;

	pix_word_t pending_pixels[$];
	int        errors      = 0;
	int        n_sent      = 0;
	int        n_checked   = 0;
	int        sink_hold   = 0;
	bit        src_idle_on = 1'b1;
	bit        sink_idle_on = 1'b1;

	display_strip_test_pattern #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H),
		.MAX_STRIP   (MAX_STRIP)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.restart     (restart),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.pixel       (pixel),
		.column      (column),
		.line        (line),
		.strip_number(strip_number),
		.frame_end   (frame_end)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] strip_rows(input logic [CFG_W-1:0] h);
		int c;
		c = h;
		if (c < 2) c = 2;
		if (c > MAX_STRIP) c = MAX_STRIP;
		return 8'(c & ~1);
	endfunction

	function automatic logic [15:0] checker_color(input int x, input int y);
		return (((x >> 4) ^ (y >> 4)) & 1) ? PIX_WHITE : PIX_BLACK;
	endfunction

	function automatic logic [15:0] grid_color(input int x, input int y);
		int row, top, span, mid, lo, hi, gx;
		row  = ras_row;
		top  = y - row;
		span = ras_rows;
		if (span > FRAME_H - top) span = FRAME_H - top;
		mid = span / 2;
		lo  = (mid >= BAR_HALF) ? mid - BAR_HALF : 0;
		hi  = mid + BAR_HALF;
		if (row >= lo && row < hi && row < span) begin
			gx = GAP_ORIGIN + ras_gap * GAP_PITCH;
			return (x >= gx && x < gx + GAP_WIDTH) ? PIX_BLACK : PIX_WHITE;
		end
		return checker_color(x, y);
	endfunction

	task automatic frame_home();
		ras_col   = '0;
		ras_line  = '0;
		ras_row   = '0;
		ras_strip = '0;
		ras_gap   = '0;
		ras_rows  = strip_rows(cur_height);
	endtask

	task automatic raster_step(input logic rst_bit);
		pix_word_t w;
		int x, y;
		if (rst_bit) frame_home();
		x = ras_col;
		y = ras_line;
		case (cur_mode)
			MODE_BLACK:   w.pixel = PIX_BLACK;
			MODE_WHITE:   w.pixel = PIX_WHITE;
			MODE_CHECKER: w.pixel = checker_color(x, y);
			default:      w.pixel = grid_color(x, y);
		endcase
		w.column       = 9'(x);
		w.line         = 9'(y);
		w.strip_number = (cur_mode == MODE_GRID) ? ras_strip : 8'd0;
		w.frame_end    = (x == FRAME_W - 1 && y == FRAME_H - 1);
		pending_pixels.push_back(w);
		n_sent++;
		if (w.frame_end) begin
			frame_home();
		end else if (x + 1 >= FRAME_W) begin
			ras_col  = '0;
			ras_line = 9'(y + 1);
			ras_row  = ras_row + 8'd1;
			if (ras_row >= ras_rows) begin
				ras_row   = '0;
				ras_strip = ras_strip + 8'd1;
				ras_gap   = (ras_gap == GAP_LAST) ? 4'd0 : ras_gap + 4'd1;
			end
			if (y + 1 >= FRAME_H) frame_home();
		end else begin
			ras_col = 9'(x + 1);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	initial begin
		pix_word_t w;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				n_checked++;
				if (pending_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected word expected none actual pixel %0h col %0d line %0d",
						$time, pixel, column, line);
				end else begin
					w = pending_pixels.pop_front();
					check_field("pixel", w.pixel, pixel);
					check_field("column", 16'(w.column), 16'(column));
					check_field("line", 16'(w.line), 16'(line));
					check_field("strip_number", 16'(w.strip_number), 16'(strip_number));
					check_field("frame_end", 16'(w.frame_end), 16'(frame_end));
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !(sink_idle_on && $urandom_range(99) < 24);
			end
		end
	end

	task automatic send_word(input logic rst_bit);
		if (src_idle_on && $urandom_range(99) < 24) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 24);
		end
		item_valid <= 1'b1;
		restart    <= rst_bit;
		do @(posedge clk); while (!item_ready);
		raster_step(rst_bit);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PATTERN_MODE) cur_mode = mode_t'(data[1:0]);
		else cur_height = data;
	endtask

	task automatic set_mode(input mode_t m);
		write_reg(REG_PATTERN_MODE, {8'($urandom_range(255)), m});
	endtask

	task automatic test_reset_values();
		repeat (3) send_word(1'b0);
		drain();
	endtask

	task automatic test_modes();
		mode_t m;
		m = m.first();
		do begin
			set_mode(m);
			send_word(1'b1);
			send_word(1'b0);
			drain();
			m = m.next();
		end while (m != m.first());
	endtask

	task automatic test_height_clamp();
		int heights[5] = '{0, 1, 3, 251, 1023};
		set_mode(MODE_GRID);
		foreach (heights[i]) begin
			write_reg(REG_STRIP_HEIGHT, CFG_W'(heights[i]));
			send_word(1'b1);
			send_word(1'b0);
			drain();
		end
	endtask

	task automatic test_strip_step();
		write_reg(REG_STRIP_HEIGHT, 10'd3);
		send_word(1'b1);
		repeat (2 * FRAME_W + 40) send_word(1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		sink_hold = 200;
		repeat (40) send_word($urandom_range(19) == 0);
		drain();
	endtask

	task automatic test_no_idle();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		set_mode(MODE_GRID);
		write_reg(REG_STRIP_HEIGHT, 10'd40);
		send_word(1'b1);
		repeat (50) send_word(1'b0);
		drain();
		write_reg(REG_STRIP_HEIGHT, 10'd1023);
		repeat (30) send_word(1'b0);
		send_word(1'b1);
		repeat (30) send_word(1'b0);
		drain();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	task automatic test_random_raster();
		int count, burst;
		count = 0;
		while (count < 100) begin
			set_mode(mode_t'($urandom_range(3)));
			if ($urandom_range(9) == 0) write_reg(REG_STRIP_HEIGHT, CFG_W'($urandom_range(1023)));
			else write_reg(REG_STRIP_HEIGHT, CFG_W'($urandom_range(20)));
			burst = $urandom_range(20, 60);
			repeat (burst) send_word($urandom_range(39) == 0);
			count += burst;
			drain();
		end
	endtask

	initial begin
		frame_home();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_modes();
		test_height_clamp();
		test_strip_step();
		test_backpressure();
		test_no_idle();
		test_random_raster();
		drain();
		repeat (10) @(posedge clk);
		$display("Checked %0d of %0d pixels over all four modes, clamped strip heights,",
			n_checked, n_sent);
		$display("a strip step across line ends, restarts, a long output stall and idling.");
		if (errors == 0) begin
			$display("display_strip_test_pattern: match");
		end else begin
			$display("display_strip_test_pattern: mismatch");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("display_strip_test_pattern: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
